>>> sv/audit_writer_list_and_log_unit_assert.svh
// Assertion macros for the audit writer list and log unit.
// Included by the top level; no other dependencies.
`ifndef AUDIT_WRITER_LIST_AND_LOG_UNIT_ASSERT_SVH
`define AUDIT_WRITER_LIST_AND_LOG_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define AWLU_CHECK_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("awlu assertion failed");
// next-cycle implication
`define AWLU_CHECK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("awlu assertion failed");
`else
`define AWLU_CHECK_NOW(lbl, pre, post)
`define AWLU_CHECK_NEXT(lbl, pre, post)
`endif

`endif

>>> sv/awlu_pkg.sv
// Shared constants, codes and types for the audit writer list and log unit.
// No dependencies.
package awlu_pkg;

  localparam int MAX_WRITERS = 16;
  localparam int LOG_DEPTH   = 256;

  localparam int ID_W   = 8;
  localparam int CODE_W = 16;
  localparam int REC_W  = ID_W + CODE_W + 1;
  localparam int WCNT_W = $clog2(MAX_WRITERS + 1);
  localparam int STEP_W = $clog2(MAX_WRITERS + 1);
  localparam int SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  localparam logic [1:0] FN_REG    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_POST   = 2'd2;
  localparam logic [1:0] FN_DRAIN  = 2'd3;

  // control broadcast to every list cell
  typedef struct packed {
    logic clear;  // drop match flags at the start of an item
    logic step;   // advance the match wave by one cell
    logic shift;  // cells at or past the match take their right neighbor
    logic load;   // cell at the tail position takes the key
  } awlu_ctl_t;

endpackage

>>> sv/awlu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module awlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/awlu_cell.sv
// One entry of the writer allow-list chain.
// Depends on awlu_pkg for widths and the control struct.
module awlu_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  awlu_pkg::awlu_ctl_t    ctl,
  input  logic [awlu_pkg::ID_W-1:0] key,
  input  logic                   live,
  input  logic                   here,
  input  logic                   prev_flag,
  input  logic [awlu_pkg::ID_W-1:0] next_id,
  output logic [awlu_pkg::ID_W-1:0] id,
  output logic                   flag
);
  import awlu_pkg::*;

  logic match;

  assign match = live && (id == key);

  // flag settles to "a live match exists at or left of this cell"
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctl.clear) begin
      flag <= 1'b0;
    end else if (ctl.step) begin
      flag <= prev_flag | match;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && here) begin
      id <= key;
    end else if (ctl.shift && flag) begin
      id <= next_id;
    end
  end

endmodule

>>> sv/audit_writer_list_and_log_unit.sv
// Top level of the audit writer list and log unit: sequencer, mailbox,
// record counter and log memory. Depends on awlu_pkg, awlu_cell, awlu_ram
// and the assertion header.

// One transaction in, one result out. Each item is accepted in S_IDLE,
// then the match flag ripples through the chain of list cells in S_SCAN,
// one cell per cycle, and S_APPLY applies the update and loads the result
// register. A new item is accepted while the previous result still waits on
// m_tready; the apply cycle waits only if that result has not been taken
// yet. The log memory needs no clearing pass and is never read back.
module audit_writer_list_and_log_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // reader_id
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // tid[7:0], event_code[23:8], event_ok[24]
  input  logic [1:0]  s_tuser,     // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata      // done_ok[0], list_full[1], writer_count[6:2],
                                   // pending[7], log_slot[15:8], log_order[47:16],
                                   // rec_writer[55:48], rec_event[71:56], rec_ok[72]
);
  import awlu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t state;
  logic [STEP_W-1:0] step_cnt;

  logic [7:0]        reader_id;
  logic [1:0]        st_func;
  logic [ID_W-1:0]   st_tid;
  logic [CODE_W-1:0] st_code;
  logic              st_ok;

  logic [WCNT_W-1:0] wr_total, wr_total_next;
  logic [ID_W-1:0]   box_writer, box_writer_next;
  logic [CODE_W-1:0] box_event, box_event_next;
  logic              box_ok, box_ok_next;
  logic              box_full, box_full_next;
  logic [31:0]       record_order, record_order_next;
  logic [SLOT_W-1:0] slot_ptr, slot_ptr_next;

  logic              done_ok, done_ok_next;
  logic              list_full, list_full_next;
  logic [4:0]        writer_count;
  logic              pending;
  logic [7:0]        log_slot, log_slot_next;
  logic [31:0]       log_order;
  logic [ID_W-1:0]   rec_writer;
  logic [CODE_W-1:0] rec_event;
  logic              rec_ok;

  logic       accept, advance, found, log_we;
  logic [31:0] total32, slot32;
  awlu_ctl_t  ctl;

  logic [ID_W-1:0] ids   [MAX_WRITERS];
  logic            flags [MAX_WRITERS];

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign advance  = (state == S_APPLY) && (!m_tvalid || m_tready);
  assign found    = flags[MAX_WRITERS-1];

  // ---------------- list chain ----------------
  genvar g;
  generate
    for (g = 0; g < MAX_WRITERS; g++) begin : g_cell
      logic            prev_f;
      logic [ID_W-1:0] nxt;
      if (g == 0) begin : g_first
        assign prev_f = 1'b0;
      end else begin : g_mid
        assign prev_f = flags[g-1];
      end
      if (g == MAX_WRITERS - 1) begin : g_last
        assign nxt = ids[g];
      end else begin : g_inner
        assign nxt = ids[g+1];
      end
      awlu_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .key       (st_tid),
        .live      (WCNT_W'(g) < wr_total),
        .here      (wr_total == WCNT_W'(g)),
        .prev_flag (prev_f),
        .next_id   (nxt),
        .id        (ids[g]),
        .flag      (flags[g])
      );
    end
  endgenerate

  // ---------------- apply logic ----------------
  always_comb begin
    wr_total_next     = wr_total;
    box_writer_next   = box_writer;
    box_event_next    = box_event;
    box_ok_next       = box_ok;
    box_full_next     = box_full;
    record_order_next = record_order;
    slot_ptr_next     = slot_ptr;
    done_ok_next      = 1'b0;
    list_full_next    = 1'b0;
    log_slot_next     = 8'd0;
    log_we            = 1'b0;
    ctl.clear         = accept;
    ctl.step          = (state == S_SCAN);
    ctl.shift         = 1'b0;
    ctl.load          = 1'b0;
    slot32            = 32'(slot_ptr);
    case (st_func)
      FN_REG: begin
        if (!found) begin
          if (wr_total >= WCNT_W'(MAX_WRITERS)) begin
            list_full_next = 1'b1;
          end else begin
            ctl.load      = advance;
            wr_total_next = wr_total + 1'b1;
            done_ok_next  = 1'b1;
          end
        end
      end
      FN_REMOVE: begin
        if (found) begin
          ctl.shift     = advance;
          wr_total_next = wr_total - 1'b1;
          done_ok_next  = 1'b1;
        end
      end
      FN_POST: begin
        if (found) begin
          box_writer_next = st_tid;
          box_event_next  = st_code;
          box_ok_next     = st_ok;
          box_full_next   = 1'b1;
          done_ok_next    = 1'b1;
        end
      end
      default: begin
        if (box_full && (st_tid == reader_id)) begin
          log_we            = advance;
          log_slot_next     = slot32[7:0];
          record_order_next = record_order + 32'd1;
          slot_ptr_next     = (slot_ptr == SLOT_W'(LOG_DEPTH - 1)) ? '0
                                                                  : slot_ptr + 1'b1;
          box_full_next     = 1'b0;
          done_ok_next      = 1'b1;
        end
      end
    endcase
  end

  awlu_ram #(
    .WIDTH (REC_W),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr (slot_ptr),
    .wdata ({box_writer, box_event, box_ok}),
    .raddr (slot_ptr),
    .rdata ()
  );

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      reader_id <= 8'd0;
    end else if (cfg_we) begin
      reader_id <= cfg_wdata;
    end
  end

  // ---------------- sequencer, state and result register ----------------
  assign total32 = 32'(wr_total_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_cnt     <= '0;
      m_tvalid     <= 1'b0;
      wr_total     <= '0;
      box_writer   <= '0;
      box_event    <= '0;
      box_ok       <= 1'b0;
      box_full     <= 1'b0;
      record_order <= 32'd0;
      slot_ptr     <= '0;
    end else begin
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            st_func  <= s_tuser;
            st_tid   <= s_tdata[7:0];
            st_code  <= s_tdata[23:8];
            st_ok    <= s_tdata[24];
            step_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(MAX_WRITERS - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (advance) begin
            wr_total     <= wr_total_next;
            box_writer   <= box_writer_next;
            box_event    <= box_event_next;
            box_ok       <= box_ok_next;
            box_full     <= box_full_next;
            record_order <= record_order_next;
            slot_ptr     <= slot_ptr_next;
            done_ok      <= done_ok_next;
            list_full    <= list_full_next;
            writer_count <= total32[4:0];
            pending      <= box_full_next;
            log_slot     <= log_slot_next;
            log_order    <= record_order_next;
            rec_writer   <= box_writer_next;
            rec_event    <= box_event_next;
            rec_ok       <= box_ok_next;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'd0, rec_ok, rec_event, rec_writer, log_order, log_slot,
                    pending, writer_count, list_full, done_ok};

  // ---------------- assertions ----------------
`include "audit_writer_list_and_log_unit_assert.svh"

  `AWLU_CHECK_NOW(a_total_max, 1'b1, wr_total <= WCNT_W'(MAX_WRITERS))
  `AWLU_CHECK_NEXT(a_total_step, 1'b1, (wr_total == $past(wr_total)) || (wr_total == $past(wr_total) + 1'b1) || (wr_total + 1'b1 == $past(wr_total)))
  `AWLU_CHECK_NOW(a_box_drain, $fell(box_full) && !$past(rst), $past(st_func) == FN_DRAIN)
  `AWLU_CHECK_NOW(a_apply_scanned, state == S_APPLY, step_cnt == STEP_W'(MAX_WRITERS))

endmodule
